@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the pixel mapper checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IHPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IHPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ihpm_pkg.sv @@
// ----------------------------------------------------------------------------
// ihpm_pkg
// Shared types and constants of the inverse homography pixel mapper.
// ----------------------------------------------------------------------------
package ihpm_pkg;

  // request codes
  localparam logic [1:0] REQ_COEF = 2'd0;
  localparam logic [1:0] REQ_SIZE = 2'd1;
  localparam logic [1:0] REQ_MAP  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_CANVAS_W = 3'd0;
  localparam logic [2:0] CFG_CANVAS_H = 3'd1;
  localparam logic [2:0] CFG_GLOBAL_W = 3'd2;
  localparam logic [2:0] CFG_GLOBAL_H = 3'd3;
  localparam logic [2:0] CFG_IMAGES   = 3'd4;

  localparam int CFG_DATA_W = 15;
  localparam int SIZE_W     = 13;
  localparam int GSIZE_W    = 15;
  localparam int PIX_W      = 12;
  localparam int COEF_W     = 32;
  localparam int IMG_W      = 3;
  localparam int CIDX_W     = 4;
  localparam int COORD_W    = 28;
  localparam int GLB_W      = 43;  // global coordinate, unsigned Q27.16
  localparam int QUO_W      = 29;  // projected coordinate incl. range bit
  localparam int ACC_W      = 64;
  localparam int NCOEF      = 9;

  localparam logic [SIZE_W-1:0]  SIZE_CAP  = 13'd4096;
  localparam logic [CIDX_W-1:0]  CIDX_LAST = 4'd8;

  // table write request, top level to table memories
  typedef struct packed {
    logic                 coef_we;
    logic                 size_we;
    logic [IMG_W-1:0]     image;
    logic [CIDX_W-1:0]    coef_index;
    logic [COEF_W-1:0]    coef_value;
    logic [2*SIZE_W-1:0]  size;      // height in upper half, width in lower
  } tbl_wr_t;

endpackage

@@ sv/ihpm_tables.sv @@
// ----------------------------------------------------------------------------
// ihpm_tables
// Coefficient and image size memories, one write and one registered read each.
// ----------------------------------------------------------------------------
module ihpm_tables #(
  parameter int MAX_IMAGES = 8,
  parameter int CAW = $clog2(MAX_IMAGES * ihpm_pkg::NCOEF),
  parameter int SAW = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1
) (
  input  logic                               clk,
  input  ihpm_pkg::tbl_wr_t                  wr,
  input  logic                               coef_re,
  input  logic [CAW-1:0]                     coef_raddr,
  output logic [ihpm_pkg::COEF_W-1:0]        coef_rdata,
  input  logic [SAW-1:0]                     size_raddr,
  output logic [2*ihpm_pkg::SIZE_W-1:0]      size_rdata
);

  logic [ihpm_pkg::COEF_W-1:0]   coef_mem [MAX_IMAGES * ihpm_pkg::NCOEF];
  logic [2*ihpm_pkg::SIZE_W-1:0] size_mem [MAX_IMAGES];

  logic           img_ok;
  logic           coef_ok;
  logic [CAW-1:0] coef_waddr;

  assign img_ok     = int'(wr.image) < MAX_IMAGES;
  assign coef_ok    = img_ok && (wr.coef_index <= ihpm_pkg::CIDX_LAST);
  assign coef_waddr = CAW'(int'(wr.image) * ihpm_pkg::NCOEF + int'(wr.coef_index));

  always_ff @(posedge clk) begin
    if (wr.coef_we && coef_ok) begin
      coef_mem[coef_waddr] <= wr.coef_value;
    end
    if (coef_re) begin
      coef_rdata <= coef_mem[coef_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.size_we && img_ok) begin
      size_mem[SAW'(wr.image)] <= wr.size;
    end
    size_rdata <= size_mem[size_raddr];
  end

endmodule

@@ sv/ihpm_div.sv @@
// ----------------------------------------------------------------------------
// ihpm_div
// Restoring divider, one quotient bit per cycle, preset partial remainder.
// ----------------------------------------------------------------------------
module ihpm_div #(
  parameter int QW = 29,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] rem_init,  // must be below den
  input  logic [QW-1:0] num,       // dividend bits shifted in, MSB first
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          done
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r;
  logic [QW-1:0] quo_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [DW:0] part;
  logic [DW:0] diff;
  logic        ge;

  assign part = {rem_r, quo_r[QW-1]};
  assign diff = part - {1'b0, den_r};
  assign ge   = part >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : part[DW-1:0];
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

@@ sv/inverse_homography_pixel_mapper_unit.sv @@
// ----------------------------------------------------------------------------
// inverse_homography_pixel_mapper_unit
// Maps canvas pixels into the best covering local image by inverse homography.
// ----------------------------------------------------------------------------
// Items on the input channel either load a table entry (one homography
// coefficient or one local image size) or map one canvas pixel. Table loads
// give no result. A map item gives exactly one result and occupies the block
// until its result sits in the output register: a divide by the canvas size
// with a 43-bit quotient scales the pixel to global coordinates, then per
// image in use come coefficient reads and multiply-accumulate out of the
// coefficient memory (one entry per cycle), the check state, and for a
// candidate hit a divide for u and v (one bit per cycle, both in parallel)
// plus the distance states, squaring and compare. An image that fails the
// sign/range screen is left after the check, one that fails only the final
// range test after the divide. Table entries must be written before a map
// item reads them. The user must write configuration only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module inverse_homography_pixel_mapper_unit #(
  parameter int MAX_IMAGES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_addr,
  input  logic [ihpm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_req_type,
  input  logic [ihpm_pkg::IMG_W-1:0]          in_image_index,
  input  logic [ihpm_pkg::CIDX_W-1:0]         in_coef_index,
  input  logic signed [ihpm_pkg::COEF_W-1:0]  in_coef_value,
  input  logic [ihpm_pkg::SIZE_W-1:0]         in_local_width,
  input  logic [ihpm_pkg::SIZE_W-1:0]         in_local_height,
  input  logic [ihpm_pkg::PIX_W-1:0]          in_pixel_x,
  input  logic [ihpm_pkg::PIX_W-1:0]          in_pixel_y,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic [ihpm_pkg::IMG_W-1:0]          out_best_image,
  output logic [ihpm_pkg::COORD_W-1:0]        out_u_coord,
  output logic [ihpm_pkg::COORD_W-1:0]        out_v_coord
);

  localparam int KW  = $clog2(MAX_IMAGES + 1);
  localparam int CAW = $clog2(MAX_IMAGES * ihpm_pkg::NCOEF);
  localparam int SAW = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
  localparam int SW  = ihpm_pkg::SIZE_W;
  localparam int GW  = ihpm_pkg::GLB_W;
  localparam int AW  = ihpm_pkg::ACC_W;
  localparam int QW  = ihpm_pkg::QUO_W;
  localparam int CRW = ihpm_pkg::COORD_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GDIV = 3'd1;  // scale pixel to global coordinates
  localparam logic [2:0] S_RD   = 3'd2;  // read and accumulate one homography
  localparam logic [2:0] S_PCHK = 3'd3;  // sign / range screen, launch divide
  localparam logic [2:0] S_PDIV = 3'd4;  // u and v divide
  localparam logic [2:0] S_SQ   = 3'd5;  // squared offsets from centre
  localparam logic [2:0] S_CMP  = 3'd6;  // keep nearest hit
  localparam logic [2:0] S_DONE = 3'd7;  // hand result to output register

  // configuration registers
  logic [SW-1:0]                    cw_r, ch_r;
  logic [ihpm_pkg::GSIZE_W-1:0]     gw_r, gh_r;
  logic [3:0]                       niu_r;

  logic [2:0]    state_r, state_nxt;
  logic [KW-1:0] k_r;          // image under test
  logic [3:0]    cnt_r;        // coefficient read counter
  logic [KW-1:0] count;
  logic [KW-1:0] k_inc;
  logic          last_img;

  logic          in_acc;
  logic          map_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r  <= SW'(1);
      ch_r  <= SW'(1);
      gw_r  <= ihpm_pkg::GSIZE_W'(1);
      gh_r  <= ihpm_pkg::GSIZE_W'(1);
      niu_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ihpm_pkg::CFG_CANVAS_W: cw_r  <= cfg_wdata[SW-1:0];
        ihpm_pkg::CFG_CANVAS_H: ch_r  <= cfg_wdata[SW-1:0];
        ihpm_pkg::CFG_GLOBAL_W: gw_r  <= cfg_wdata;
        ihpm_pkg::CFG_GLOBAL_H: gh_r  <= cfg_wdata;
        ihpm_pkg::CFG_IMAGES:   niu_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // images_in_use saturates at the table depth
  assign count    = (int'(niu_r) > MAX_IMAGES) ? KW'(MAX_IMAGES) : KW'(niu_r);
  assign k_inc    = k_r + KW'(1);
  assign last_img = (k_inc == count);

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign map_start = in_acc && (in_req_type == ihpm_pkg::REQ_MAP);

  // ---------------------------------------------------------------- tables
  ihpm_pkg::tbl_wr_t            tbl_wr;
  logic                         coef_re;
  logic [ihpm_pkg::COEF_W-1:0]  coef_rdata;
  logic [2*SW-1:0]              size_rdata;
  logic [SW-1:0]                wcap, hcap;
  logic [SW-1:0]                lw, lh;

  assign wcap = (in_local_width  > ihpm_pkg::SIZE_CAP) ? ihpm_pkg::SIZE_CAP : in_local_width;
  assign hcap = (in_local_height > ihpm_pkg::SIZE_CAP) ? ihpm_pkg::SIZE_CAP : in_local_height;

  always_comb begin
    tbl_wr.coef_we    = in_acc && (in_req_type == ihpm_pkg::REQ_COEF);
    tbl_wr.size_we    = in_acc && (in_req_type == ihpm_pkg::REQ_SIZE);
    tbl_wr.image      = in_image_index;
    tbl_wr.coef_index = in_coef_index;
    tbl_wr.coef_value = in_coef_value;
    tbl_wr.size       = {hcap, wcap};
  end

  assign coef_re = (state_r == S_RD) && (cnt_r < 4'd9);

  ihpm_tables #(
    .MAX_IMAGES (MAX_IMAGES),
    .CAW        (CAW),
    .SAW        (SAW)
  ) u_tables (
    .clk        (clk),
    .wr         (tbl_wr),
    .coef_re    (coef_re),
    .coef_raddr (CAW'(int'(k_r) * ihpm_pkg::NCOEF + int'(cnt_r))),
    .coef_rdata (coef_rdata),
    .size_raddr (SAW'(k_r)),
    .size_rdata (size_rdata)
  );

  assign lw = size_rdata[SW-1:0];
  assign lh = size_rdata[2*SW-1:SW];

  // ------------------------------------------------------ global scaling
  // g = floor(p * gsize * 2^16 / csize), zero canvas size acts as one
  logic [26:0]   prod_x, prod_y;
  logic [GW-1:0] gx, gy;
  logic          gx_done, gy_done;

  assign prod_x = 27'(in_pixel_x) * 27'(gw_r);
  assign prod_y = 27'(in_pixel_y) * 27'(gh_r);

  ihpm_div #(.QW(GW), .DW(SW)) u_div_gx (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (map_start),
    .rem_init ('0),
    .num      ({prod_x, 16'd0}),
    .den      ((cw_r == '0) ? SW'(1) : cw_r),
    .quo      (gx),
    .done     (gx_done)
  );

  ihpm_div #(.QW(GW), .DW(SW)) u_div_gy (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (map_start),
    .rem_init ('0),
    .num      ({prod_y, 16'd0}),
    .den      ((ch_r == '0) ? SW'(1) : ch_r),
    .quo      (gy),
    .done     (gy_done)
  );

  // ------------------------------------------- multiply-accumulate pipeline
  // stage 1: memory read data, stage 2: registered products, stage 3: sums
  logic                 v1_r, v2_r;
  logic [3:0]           j1_r;
  logic [1:0]           row1, col1, row2_r;
  logic                 first2_r;
  logic [GW-1:0]        gsel;
  logic signed [59:0]   mhi;
  logic signed [48:0]   mlo;
  logic signed [AW-1:0] phi_r, plo_r, psum;
  logic signed [AW-1:0] acc_u_r, acc_v_r, acc_w_r;
  logic signed [ihpm_pkg::COEF_W-1:0] cval;

  always_comb begin
    unique case (j1_r)
      4'd0:    begin row1 = 2'd0; col1 = 2'd0; end
      4'd1:    begin row1 = 2'd0; col1 = 2'd1; end
      4'd2:    begin row1 = 2'd0; col1 = 2'd2; end
      4'd3:    begin row1 = 2'd1; col1 = 2'd0; end
      4'd4:    begin row1 = 2'd1; col1 = 2'd1; end
      4'd5:    begin row1 = 2'd1; col1 = 2'd2; end
      4'd6:    begin row1 = 2'd2; col1 = 2'd0; end
      4'd7:    begin row1 = 2'd2; col1 = 2'd1; end
      default: begin row1 = 2'd2; col1 = 2'd2; end
    endcase
  end

  // c*g formed as c*int(g) + floor(c*frac(g) / 2^16)
  assign cval = $signed(coef_rdata);
  assign gsel = (col1 == 2'd0) ? gx : gy;
  assign mhi  = cval * $signed({1'b0, gsel[GW-1:16]});
  assign mlo  = cval * $signed({1'b0, gsel[15:0]});
  assign psum = phi_r + plo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= coef_re;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    j1_r     <= cnt_r;
    row2_r   <= row1;
    first2_r <= (col1 == 2'd0);
    if (col1 == 2'd2) begin
      phi_r <= {{(AW-32){cval[31]}}, cval};
      plo_r <= '0;
    end else begin
      phi_r <= {{(AW-60){mhi[59]}}, mhi};
      plo_r <= {{(AW-33){mlo[48]}}, mlo[48:16]};
    end
    if (v2_r) begin
      unique case (row2_r)
        2'd0:    acc_u_r <= first2_r ? psum : acc_u_r + psum;
        2'd1:    acc_v_r <= first2_r ? psum : acc_v_r + psum;
        default: acc_w_r <= first2_r ? psum : acc_w_r + psum;
      endcase
    end
  end

  // ------------------------------------------------------ projection check
  logic [AW-1:0]    mag_u, mag_v, mag_w;
  logic             sign_ok_u, sign_ok_v;
  logic             pre_ok;
  logic [QW-1:0]    quo_u, quo_v;
  logic             pdiv_done;
  logic             pdiv_start;
  logic             unused_v_done;

  assign mag_u = acc_u_r[AW-1] ? AW'(-acc_u_r) : acc_u_r;
  assign mag_v = acc_v_r[AW-1] ? AW'(-acc_v_r) : acc_v_r;
  assign mag_w = acc_w_r[AW-1] ? AW'(-acc_w_r) : acc_w_r;

  assign sign_ok_u = (acc_u_r == '0) || (acc_u_r[AW-1] == acc_w_r[AW-1]);
  assign sign_ok_v = (acc_v_r == '0) || (acc_v_r[AW-1] == acc_w_r[AW-1]);

  // quotient of 8192 or more can never fit a 4096-pixel image
  assign pre_ok = (acc_w_r != '0) && sign_ok_u && sign_ok_v &&
                  ({13'd0, mag_u} < {mag_w, 13'd0}) &&
                  ({13'd0, mag_v} < {mag_w, 13'd0});

  assign pdiv_start = (state_r == S_PCHK) && pre_ok;

  ihpm_div #(.QW(QW), .DW(AW)) u_div_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (pdiv_start),
    .rem_init (AW'(mag_u[AW-1:13])),
    .num      ({mag_u[12:0], 16'd0}),
    .den      (mag_w),
    .quo      (quo_u),
    .done     (pdiv_done)
  );

  ihpm_div #(.QW(QW), .DW(AW)) u_div_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (pdiv_start),
    .rem_init (AW'(mag_v[AW-1:13])),
    .num      ({mag_v[12:0], 16'd0}),
    .den      (mag_w),
    .quo      (quo_v),
    .done     (unused_v_done)
  );

  // ---------------------------------------------------- distance and best
  logic [CRW-1:0]            u_r, v_r;
  logic [CRW-1:0]            cu, cv, du, dv;
  logic [2*CRW-1:0]          squ_r, sqv_r;
  logic [2*CRW:0]            sq_dist;
  logic                      in_range;
  logic                      hit_r;
  logic [ihpm_pkg::IMG_W-1:0] best_img_r;
  logic [CRW-1:0]            best_u_r, best_v_r;
  logic [2*CRW:0]            best_d_r;

  assign in_range = (quo_u[QW-1:16] < lw) && (quo_v[QW-1:16] < lh) && unused_v_done;
  assign cu      = {lw, 15'd0};
  assign cv      = {lh, 15'd0};
  assign du      = (u_r >= cu) ? (u_r - cu) : (cu - u_r);
  assign dv      = (v_r >= cv) ? (v_r - cv) : (cv - v_r);
  assign sq_dist = {1'b0, squ_r} + {1'b0, sqv_r};

  always_ff @(posedge clk) begin
    if (state_r == S_PDIV && pdiv_done) begin
      u_r <= quo_u[CRW-1:0];
      v_r <= quo_v[CRW-1:0];
    end
    if (state_r == S_SQ) begin
      squ_r <= du * du;
      sqv_r <= dv * dv;
    end
  end

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (map_start) state_nxt = S_GDIV;
      S_GDIV: if (gx_done && gy_done) state_nxt = (count == '0) ? S_DONE : S_RD;
      S_RD:   if (cnt_r == 4'd10) state_nxt = S_PCHK;
      S_PCHK: begin
        if (pre_ok)        state_nxt = S_PDIV;
        else if (last_img) state_nxt = S_DONE;
        else               state_nxt = S_RD;
      end
      S_PDIV: begin
        if (pdiv_done) begin
          if (in_range)      state_nxt = S_SQ;
          else if (last_img) state_nxt = S_DONE;
          else               state_nxt = S_RD;
        end
      end
      S_SQ:   state_nxt = S_CMP;
      S_CMP:  state_nxt = last_img ? S_DONE : S_RD;
      default: if (!out_valid || !out_stall) state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      cnt_r   <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (map_start) begin
        hit_r <= 1'b0;
        k_r   <= '0;
      end
      if (state_r == S_RD) begin
        cnt_r <= cnt_r + 4'd1;
      end else begin
        cnt_r <= '0;
      end
      // advance to the next image when leaving its last state
      if ((state_r == S_PCHK && !pre_ok) ||
          (state_r == S_PDIV && pdiv_done && !in_range) ||
          (state_r == S_CMP)) begin
        k_r <= k_inc;
      end
      if (state_r == S_CMP && (!hit_r || sq_dist < best_d_r)) begin
        hit_r <= 1'b1;
      end
    end
  end

  // nearest hit wins, strict compare keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (state_r == S_CMP && (!hit_r || sq_dist < best_d_r)) begin
      best_img_r <= ihpm_pkg::IMG_W'(k_r);
      best_u_r   <= u_r;
      best_v_r   <= v_r;
      best_d_r   <= sq_dist;
    end
  end

  // ---------------------------------------------------------- output stage
  logic                       out_valid_r;
  logic                       out_found_r;
  logic [ihpm_pkg::IMG_W-1:0] out_img_r;
  logic [CRW-1:0]             out_u_r, out_v_r;
  logic                       out_load;

  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= hit_r;
      out_img_r   <= hit_r ? best_img_r : '0;
      out_u_r     <= hit_r ? best_u_r : '0;
      out_v_r     <= hit_r ? best_v_r : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_best_image = out_img_r;
  assign out_u_coord    = out_u_r;
  assign out_v_coord    = out_v_r;

endmodule

@@ sv/ihpm_checker.sv @@
// ----------------------------------------------------------------------------
// ihpm_checker
// Port-level checks of the pixel mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ihpm_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [1:0]                         in_req_type,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               out_found,
  input logic [ihpm_pkg::IMG_W-1:0]         out_best_image,
  input logic [ihpm_pkg::COORD_W-1:0]       out_u_coord,
  input logic [ihpm_pkg::COORD_W-1:0]       out_v_coord
);

  `IHPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `IHPM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_u_coord) && $stable(out_v_coord), "stalled result changed")
  `IHPM_ASSERT_NOW(a_miss_zero, out_valid && !out_found, out_best_image == '0 && out_u_coord == '0 && out_v_coord == '0, "miss carries nonzero fields")
  `IHPM_ASSERT_NEXT(a_map_busy, in_valid && !in_stall && in_req_type == ihpm_pkg::REQ_MAP, in_stall, "map item did not block input")

endmodule

bind inverse_homography_pixel_mapper_unit ihpm_checker u_ihpm_checker (.*);

@@ test/inverse_homography_pixel_mapper_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// inverse_homography_pixel_mapper_unit_tb
// Self-checking bench for the inverse homography pixel mapper.
// ----------------------------------------------------------------------------
// A short stimulus table covers the miss after reset, ignored and misaddressed
// requests, an identity mapping at the coordinate extremes, oversized, unit and
// zero local sizes, a zero w term and extreme coefficients. After that every
// image table is loaded, and randomized phases follow: each phase has its own
// register setting, and its items are mostly pixel maps and well-formed image
// loads. Map results are checked field by field against the row's typed result
// or an in-bench model of the scaling, projection and nearest-centre choice.
// ----------------------------------------------------------------------------
module inverse_homography_pixel_mapper_unit_tb;

  localparam logic [1:0] REQ_NONE   = 2'd3;  // reserved code, ignored by the block
  localparam logic [2:0] CFG_UNUSED = 3'd7;  // beyond the register list
  localparam int IDLE_LIMIT  = 5000;
  localparam int ITEM_TARGET = 1550;

  typedef struct packed {
    logic        found;
    logic [2:0]  best;
    logic [27:0] u;
    logic [27:0] v;
  } mapped_t;

  typedef struct {
    logic [1:0]  req;
    logic [2:0]  img;
    logic [3:0]  ci;
    logic [31:0] coef;
    logic [12:0] lw;
    logic [12:0] lh;
    logic [11:0] px;
    logic [11:0] py;
    bit          sync;   // drain, then enable image 0 only, before this row
    bit          typed;  // result written into the row
    mapped_t     res;
  } row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_addr;
  logic [ihpm_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid, in_stall;
  logic [1:0] in_req_type;
  logic [ihpm_pkg::IMG_W-1:0] in_image_index;
  logic [ihpm_pkg::CIDX_W-1:0] in_coef_index;
  logic signed [ihpm_pkg::COEF_W-1:0] in_coef_value;
  logic [ihpm_pkg::SIZE_W-1:0] in_local_width, in_local_height;
  logic [ihpm_pkg::PIX_W-1:0] in_pixel_x, in_pixel_y;
  logic out_valid, out_stall, out_found;
  logic [ihpm_pkg::IMG_W-1:0] out_best_image;
  logic [ihpm_pkg::COORD_W-1:0] out_u_coord, out_v_coord;

  inverse_homography_pixel_mapper_unit dut (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // mirror of the block's registers and tables
  logic signed [31:0] coef_mem [72];
  logic [12:0] width_mem [8];
  logic [12:0] height_mem [8];
  logic [12:0] canvas_w, canvas_h;
  logic [14:0] glob_w, glob_h;
  logic [3:0]  img_cnt;

  mapped_t pending_maps [$];
  row_t    directed_rows [$];
  int      errors = 0;
  int      items_sent = 0;
  int      idle_cycles = 0;
  int      rx_wait = 0;
  bit      calm = 0;  // no idling on either side in this phase

  // ---- model --------------------------------------------------------------
  // c*g with g unsigned Q.16, split so that the fraction part floors
  function automatic longint coef_mul(logic signed [31:0] c, longint unsigned g);
    longint cl, gi, gf;
    cl = c;
    gi = longint'(g >> 16);
    gf = longint'(g & 64'hFFFF);
    return cl * gi + ((cl * gf) >>> 16);
  endfunction

  // checks 0 <= num/den < lim, gives floor(|num| * 2^16 / |den|)
  function automatic bit project_axis(longint num, longint den, longint unsigned lim,
                                      output longint unsigned q16);
    longint unsigned a, b, q, r, frac;
    q16 = 0;
    frac = 0;
    if (num != 0 && ((num < 0) != (den < 0))) return 1'b0;
    a = (num < 0) ? -num : num;
    b = (den < 0) ? -den : den;
    q = a / b;
    if (q >= lim) return 1'b0;
    r = a % b;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      frac = frac << 1;
      if (r >= b) begin
        r = r - b;
        frac = frac | 1;
      end
    end
    q16 = (q << 16) | frac;
    return 1'b1;
  endfunction

  function automatic mapped_t map_pixel(logic [11:0] px, logic [11:0] py);
    longint unsigned gx, gy, cw, ch, cnt, lw, lh, u, v, du, dv, d, best_d;
    longint nu, nv, nw;
    int base;
    bit hit;
    mapped_t res;
    cw = (canvas_w == 0) ? 1 : canvas_w;
    ch = (canvas_h == 0) ? 1 : canvas_h;
    gx = ((longint'(px) << 16) * longint'(glob_w)) / cw;
    gy = ((longint'(py) << 16) * longint'(glob_h)) / ch;
    cnt = (img_cnt > 8) ? 8 : img_cnt;
    res = '0;
    hit = 1'b0;
    best_d = 0;
    for (int k = 0; k < cnt; k++) begin
      base = k * 9;
      lw = width_mem[k];
      lh = height_mem[k];
      nu = coef_mul(coef_mem[base], gx) + coef_mul(coef_mem[base+1], gy)
           + longint'(coef_mem[base+2]);
      nv = coef_mul(coef_mem[base+3], gx) + coef_mul(coef_mem[base+4], gy)
           + longint'(coef_mem[base+5]);
      nw = coef_mul(coef_mem[base+6], gx) + coef_mul(coef_mem[base+7], gy)
           + longint'(coef_mem[base+8]);
      if (nw == 0) continue;
      if (!project_axis(nu, nw, lw, u) || !project_axis(nv, nw, lh, v)) continue;
      du = (u >= (lw << 15)) ? u - (lw << 15) : (lw << 15) - u;
      dv = (v >= (lh << 15)) ? v - (lh << 15) : (lh << 15) - v;
      d = du * du + dv * dv;
      if (!hit || d < best_d) begin
        hit = 1'b1;
        best_d = d;
        res.found = 1'b1;
        res.best = k[2:0];
        res.u = u[27:0];
        res.v = v[27:0];
      end
    end
    return res;
  endfunction

  // table update for an accepted item; returns 1 when a result is due
  function automatic bit absorb_item(row_t r, output mapped_t res);
    res = '0;
    case (r.req)
      ihpm_pkg::REQ_COEF: if (r.ci <= ihpm_pkg::CIDX_LAST) coef_mem[r.img*9 + r.ci] = r.coef;
      ihpm_pkg::REQ_SIZE: begin
        width_mem[r.img]  = (r.lw > ihpm_pkg::SIZE_CAP) ? ihpm_pkg::SIZE_CAP : r.lw;
        height_mem[r.img] = (r.lh > ihpm_pkg::SIZE_CAP) ? ihpm_pkg::SIZE_CAP : r.lh;
      end
      ihpm_pkg::REQ_MAP: begin
        res = map_pixel(r.px, r.py);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---- stimulus helpers ---------------------------------------------------
  function automatic row_t mk_row(logic [1:0] req, logic [2:0] img, logic [3:0] ci,
                                  logic [31:0] coef, logic [12:0] lw, logic [12:0] lh,
                                  logic [11:0] px, logic [11:0] py);
    row_t r;
    r.req = req; r.img = img; r.ci = ci; r.coef = coef;
    r.lw = lw; r.lh = lh; r.px = px; r.py = py;
    r.sync = 1'b0; r.typed = 1'b0; r.res = '0;
    return r;
  endfunction

  function automatic row_t with_res(row_t r, logic f, logic [2:0] b,
                                    logic [27:0] u, logic [27:0] v);
    r.typed = 1'b1;
    r.res = '{f, b, u, v};
    return r;
  endfunction

  function automatic row_t mk_map(logic [11:0] px, logic [11:0] py);
    return mk_row(ihpm_pkg::REQ_MAP, 3'($urandom), 4'($urandom), $urandom,
                  13'($urandom), 13'($urandom), px, py);
  endfunction

  function automatic row_t mk_coef(logic [2:0] img, logic [3:0] ci, logic [31:0] c);
    return mk_row(ihpm_pkg::REQ_COEF, img, ci, c, 13'($urandom), 13'($urandom),
                  12'($urandom), 12'($urandom));
  endfunction

  function automatic row_t mk_size(logic [2:0] img, logic [12:0] lw, logic [12:0] lh);
    return mk_row(ihpm_pkg::REQ_SIZE, img, 4'($urandom), $urandom, lw, lh,
                  12'($urandom), 12'($urandom));
  endfunction

  function automatic logic [31:0] any_coef();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [14:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ihpm_pkg::CFG_CANVAS_W: canvas_w = val[12:0];
      ihpm_pkg::CFG_CANVAS_H: canvas_h = val[12:0];
      ihpm_pkg::CFG_GLOBAL_W: glob_w = val;
      ihpm_pkg::CFG_GLOBAL_H: glob_h = val;
      ihpm_pkg::CFG_IMAGES:   img_cnt = val[3:0];
      default: ;
    endcase
  endtask

  // all results in, then a margin for trailing table loads
  task automatic drain();
    while (pending_maps.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic send(row_t r);
    int gap;
    mapped_t res;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type <= r.req;
    in_image_index <= r.img;
    in_coef_index <= r.ci;
    in_coef_value <= r.coef;
    in_local_width <= r.lw;
    in_local_height <= r.lh;
    in_pixel_x <= r.px;
    in_pixel_y <= r.py;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (absorb_item(r, res)) pending_maps.push_back(r.typed ? r.res : res);
    items_sent++;
    @(negedge clk);
  endtask

  // one image as a plausible inverse homography: scale, offset, mild tilt
  task automatic load_image(logic [2:0] k);
    logic [31:0] h [9];
    h[0] = $urandom_range(16384, 131072);
    h[1] = $urandom_range(0, 4096) - 2048;
    h[2] = -($urandom_range(0, glob_w) * 32768);
    h[3] = $urandom_range(0, 4096) - 2048;
    h[4] = $urandom_range(16384, 131072);
    h[5] = -($urandom_range(0, glob_h) * 32768);
    h[6] = $urandom_range(0, 6) - 3;
    h[7] = $urandom_range(0, 6) - 3;
    h[8] = ($urandom_range(0, 15) == 0) ? any_coef() : 32'h0001_0000;
    for (int i = 0; i < 9; i++) send(mk_coef(k, 4'(i), h[i]));
    if ($urandom_range(0, 9) == 0) send(mk_size(k, 13'($urandom), 13'($urandom)));
    else send(mk_size(k, 13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096))));
  endtask

  // ---- result side --------------------------------------------------------
  always @(negedge clk) begin
    if (rx_wait > 0 && !calm) begin
      out_stall <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    mapped_t want;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("inverse_homography_pixel_mapper_unit_tb: FAIL");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      rx_wait = $urandom_range(0, 15);
      if (pending_maps.size() == 0) begin
        errors++;
        $display("%0t: unexpected result found=%0b image=%0d u=%h v=%h", $time,
                 out_found, out_best_image, out_u_coord, out_v_coord);
      end else begin
        want = pending_maps.pop_front();
        if (out_found !== want.found) begin
          errors++;
          $display("%0t: found exp %0b got %0b", $time, want.found, out_found);
        end
        if (out_best_image !== want.best) begin
          errors++;
          $display("%0t: best_image exp %0d got %0d", $time, want.best, out_best_image);
        end
        if (out_u_coord !== want.u) begin
          errors++;
          $display("%0t: u_coord exp %h got %h", $time, want.u, out_u_coord);
        end
        if (out_v_coord !== want.v) begin
          errors++;
          $display("%0t: v_coord exp %h got %h", $time, want.v, out_v_coord);
        end
      end
    end
  end

  // ---- main sequence ------------------------------------------------------
  initial begin
    row_t r;
    int kind;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    in_valid = 1'b0; in_req_type = '0; in_image_index = '0; in_coef_index = '0;
    in_coef_value = '0; in_local_width = '0; in_local_height = '0;
    in_pixel_x = '0; in_pixel_y = '0;
    out_stall = 1'b0;
    canvas_w = 13'd1; canvas_h = 13'd1; glob_w = 15'd1; glob_h = 15'd1; img_cnt = 4'd0;
    for (int i = 0; i < 72; i++) coef_mem[i] = '0;
    for (int i = 0; i < 8; i++) begin
      width_mem[i] = '0;
      height_mem[i] = '0;
    end

    // no image in use after reset: always a miss
    directed_rows.push_back(with_res(mk_map(12'd0, 12'd0), 1'b0, 3'd0, 28'd0, 28'd0));
    directed_rows.push_back(with_res(mk_map(12'hFFF, 12'hFFF), 1'b0, 3'd0, 28'd0, 28'd0));
    directed_rows.push_back(mk_row(REQ_NONE, '1, '1, '1, '1, '1, '1, '1));
    // coefficient indexes past the matrix are dropped
    directed_rows.push_back(mk_coef(3'd0, 4'd15, 32'h8000_0000));
    directed_rows.push_back(mk_coef(3'd7, 4'd9, 32'h7FFF_FFFF));
    // identity on image 0, size clamps to 4096
    for (int i = 0; i < 9; i++)
      directed_rows.push_back(mk_coef(3'd0, 4'(i), (i % 4 == 0) ? 32'h0001_0000 : 32'h0));
    directed_rows.push_back(mk_size(3'd0, 13'h1FFF, 13'd4097));
    r = with_res(mk_map(12'd0, 12'd0), 1'b1, 3'd0, 28'd0, 28'd0);
    r.sync = 1'b1;
    directed_rows.push_back(r);
    directed_rows.push_back(with_res(mk_map(12'hFFF, 12'hFFF), 1'b1, 3'd0,
                                     28'hFFF0000, 28'hFFF0000));
    directed_rows.push_back(with_res(mk_map(12'hFFF, 12'd0), 1'b1, 3'd0,
                                     28'hFFF0000, 28'd0));
    // 1x1 image: only the origin pixel lands
    directed_rows.push_back(mk_size(3'd0, 13'd1, 13'd1));
    directed_rows.push_back(with_res(mk_map(12'd0, 12'd0), 1'b1, 3'd0, 28'd0, 28'd0));
    directed_rows.push_back(with_res(mk_map(12'd1, 12'd0), 1'b0, 3'd0, 28'd0, 28'd0));
    // zero size never hits
    directed_rows.push_back(mk_size(3'd0, 13'd0, 13'd0));
    directed_rows.push_back(with_res(mk_map(12'd0, 12'd0), 1'b0, 3'd0, 28'd0, 28'd0));
    // zero w term skips the image
    directed_rows.push_back(mk_size(3'd0, 13'd16, 13'd16));
    directed_rows.push_back(mk_coef(3'd0, 4'd8, 32'h0));
    directed_rows.push_back(with_res(mk_map(12'd3, 12'd3), 1'b0, 3'd0, 28'd0, 28'd0));
    // extreme coefficients
    directed_rows.push_back(mk_coef(3'd0, 4'd8, 32'h8000_0000));
    directed_rows.push_back(mk_coef(3'd0, 4'd0, 32'h7FFF_FFFF));
    directed_rows.push_back(mk_map(12'd5, 12'd9));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].sync) begin
        in_valid <= 1'b0;
        drain();
        cfg_write(ihpm_pkg::CFG_IMAGES, 15'd1);
      end
      send(directed_rows[i]);
    end

    // load every table before more than one image is in use
    in_valid <= 1'b0;
    drain();
    cfg_write(ihpm_pkg::CFG_GLOBAL_W, 15'd64);
    cfg_write(ihpm_pkg::CFG_GLOBAL_H, 15'd64);
    for (int k = 0; k < 8; k++) load_image(3'(k));

    for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
      in_valid <= 1'b0;
      drain();
      calm = ($urandom_range(0, 3) == 0);
      case (ph)
        0: begin
          cfg_write(ihpm_pkg::CFG_CANVAS_W, 15'd1); cfg_write(ihpm_pkg::CFG_CANVAS_H, 15'd1);
          cfg_write(ihpm_pkg::CFG_GLOBAL_W, 15'd1); cfg_write(ihpm_pkg::CFG_GLOBAL_H, 15'd1);
          cfg_write(ihpm_pkg::CFG_IMAGES, 15'd8);
        end
        1: begin
          cfg_write(ihpm_pkg::CFG_CANVAS_W, 15'h1FFF);
          cfg_write(ihpm_pkg::CFG_CANVAS_H, 15'h1FFF);
          cfg_write(ihpm_pkg::CFG_GLOBAL_W, 15'h7FFF);
          cfg_write(ihpm_pkg::CFG_GLOBAL_H, 15'h7FFF);
          cfg_write(ihpm_pkg::CFG_IMAGES, 15'hF);
        end
        2: begin
          cfg_write(ihpm_pkg::CFG_CANVAS_W, 15'd0); cfg_write(ihpm_pkg::CFG_CANVAS_H, 15'd0);
          cfg_write(ihpm_pkg::CFG_GLOBAL_W, 15'd0); cfg_write(ihpm_pkg::CFG_GLOBAL_H, 15'd0);
          cfg_write(ihpm_pkg::CFG_IMAGES, 15'd0);
        end
        default: begin
          cfg_write(ihpm_pkg::CFG_CANVAS_W, 15'($urandom_range(1, 4096)));
          cfg_write(ihpm_pkg::CFG_CANVAS_H, 15'($urandom_range(1, 4096)));
          cfg_write(ihpm_pkg::CFG_GLOBAL_W, 15'($urandom_range(1, 8192)));
          cfg_write(ihpm_pkg::CFG_GLOBAL_H, 15'($urandom_range(1, 8192)));
          cfg_write(ihpm_pkg::CFG_IMAGES, 15'($urandom_range(1, 10)));
          if ($urandom_range(0, 2) == 0)
            cfg_write(CFG_UNUSED - 3'($urandom_range(0, 2)), 15'($urandom));
        end
      endcase
      for (int n = 0; n < 120 && items_sent < ITEM_TARGET; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 55)
          send(mk_map(12'($urandom), 12'($urandom)));
        else if (kind < 63)
          load_image(3'($urandom));
        else if (kind < 83)
          send(mk_coef(3'($urandom), 4'($urandom), any_coef()));
        else if (kind < 92)
          send(mk_size(3'($urandom), 13'($urandom), 13'($urandom)));
        else
          send(mk_row(REQ_NONE, 3'($urandom), 4'($urandom), $urandom, 13'($urandom),
                      13'($urandom), 12'($urandom), 12'($urandom)));
      end
    end

    in_valid <= 1'b0;
    while (pending_maps.size() != 0) @(negedge clk);
    repeat (500) @(negedge clk);
    if (errors == 0) begin
      $display("inverse_homography_pixel_mapper_unit_tb: PASS");
    end else begin
      $display("inverse_homography_pixel_mapper_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
